[rtl/lcs_pkg.sv]
package lcs_pkg;

    localparam int LCS_MAX_LEN = 64;
    localparam int LCS_BYTE_W  = 8;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

endpackage

[rtl/lcs_ram.sv]
module lcs_ram import lcs_pkg::*; #(
    parameter int WIDTH = LCS_BYTE_W,
    parameter int DEPTH = LCS_MAX_LEN,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/lcs_cell.sv]
module lcs_cell import lcs_pkg::*; #(
    parameter int SW = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_load,
    input  logic [LCS_BYTE_W-1:0] i_load_ch,
    input  logic                  i_vld,
    input  logic [LCS_BYTE_W-1:0] i_ch,
    input  logic [SW-1:0]         i_left,
    input  logic [SW-1:0]         i_diag,
    output logic                  o_vld,
    output logic [LCS_BYTE_W-1:0] o_ch,
    output logic [SW-1:0]         o_left,
    output logic [SW-1:0]         o_diag
);

    logic [LCS_BYTE_W-1:0] r_col_ch;
    logic [LCS_BYTE_W-1:0] r_ch;
    logic [SW-1:0]         r_score;
    logic [SW-1:0]         r_diag;
    logic                  r_vld;
    logic [SW-1:0]         n_score;

    always_comb begin
        if (i_ch == r_col_ch) begin
            n_score = i_diag + SW'(1);
        end else if (r_score > i_left) begin
            n_score = r_score;
        end else begin
            n_score = i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_col_ch <= i_load_ch;
        end
        if (i_clear) begin
            r_score <= '0;
        end else if (i_vld) begin
            // pass the old score on as the next column's diagonal
            r_diag  <= r_score;
            r_score <= n_score;
        end
        r_ch <= i_ch;
    end

    assign o_vld  = r_vld;
    assign o_ch   = r_ch;
    assign o_left = r_score;
    assign o_diag = r_diag;

endmodule

[rtl/lcs_length_engine.sv]
// Loading: one transfer per cycle, each may add a byte to either sequence.
// Run: after the transfer with i_final_item set, the engine steps through ST_RUN and then
// waits in ST_HOLD until the output register is free before o_out_valid rises.
// A row byte enters the cell chain each cycle and walks one cell per cycle.
// No input is taken during a run; the next load starts once the result is registered.
// Reset: synchronous, active low; clears counts, state and valid flags.
module lcs_length_engine import lcs_pkg::*; #(
    parameter int MAX_LEN = LCS_MAX_LEN,
    localparam int SW     = $clog2(MAX_LEN + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [LCS_BYTE_W-1:0] i_first_byte,
    input  logic                  i_first_valid,
    input  logic [LCS_BYTE_W-1:0] i_second_byte,
    input  logic                  i_second_valid,
    input  logic                  i_final_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SW-1:0]         o_common_length
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TW = $clog2(2 * MAX_LEN + 1);

    t_state r_state, n_state;
    logic [SW-1:0] r_first_count, n_first_count;
    logic [SW-1:0] r_second_count, n_second_count;
    logic [TW-1:0] r_t, n_t;
    logic          r_rd_vld, n_rd_vld;
    logic          r_out_valid, n_out_valid;
    logic [SW-1:0] r_out_data, n_out_data;

    logic          w_accept;
    logic          w_first_wr;
    logic          w_second_wr;
    logic          w_out_free;
    logic          w_run_end;
    logic [SW-1:0] w_result;
    logic [LCS_BYTE_W-1:0] w_rd_data;

    logic                  w_vld  [MAX_LEN+1];
    logic [LCS_BYTE_W-1:0] w_ch   [MAX_LEN+1];
    logic [SW-1:0]         w_left [MAX_LEN+1];
    logic [SW-1:0]         w_diag [MAX_LEN+1];

    assign o_in_stall  = (r_state != ST_LOAD);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_first_wr  = w_accept && i_first_valid && (r_first_count < SW'(MAX_LEN));
    assign w_second_wr = w_accept && i_second_valid && (r_second_count < SW'(MAX_LEN));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_run_end   = (r_t == TW'(r_first_count) + TW'(MAX_LEN));

    lcs_ram #(
        .WIDTH (LCS_BYTE_W),
        .DEPTH (MAX_LEN)
    ) u_first_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_first_wr),
        .i_wr_addr (r_first_count[AW-1:0]),
        .i_wr_data (i_first_byte),
        .i_rd_addr (r_t[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_vld[0]  = r_rd_vld;
    assign w_ch[0]   = w_rd_data;
    assign w_left[0] = '0;
    assign w_diag[0] = '0;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        lcs_cell #(
            .SW (SW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (w_accept && i_final_item),
            .i_load    (w_second_wr && (r_second_count == SW'(g))),
            .i_load_ch (i_second_byte),
            .i_vld     (w_vld[g]),
            .i_ch      (w_ch[g]),
            .i_left    (w_left[g]),
            .i_diag    (w_diag[g]),
            .o_vld     (w_vld[g+1]),
            .o_ch      (w_ch[g+1]),
            .o_left    (w_left[g+1]),
            .o_diag    (w_diag[g+1])
        );
    end

    // score of the last column that holds a second-sequence byte
    always_comb begin
        if (r_second_count == '0) begin
            w_result = '0;
        end else begin
            w_result = w_left[r_second_count];
        end
    end

    always_comb begin
        n_state        = r_state;
        n_first_count  = r_first_count;
        n_second_count = r_second_count;
        n_t            = r_t;
        n_rd_vld       = 1'b0;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_data     = r_out_data;
        unique case (r_state)
            ST_LOAD: begin
                if (w_first_wr) begin
                    n_first_count = r_first_count + SW'(1);
                end
                if (w_second_wr) begin
                    n_second_count = r_second_count + SW'(1);
                end
                if (w_accept && i_final_item) begin
                    n_t     = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_rd_vld = (r_t < TW'(r_first_count));
                if (w_run_end) begin
                    n_state = ST_HOLD;
                end else begin
                    n_t = r_t + TW'(1);
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_data     = w_result;
                    n_first_count  = '0;
                    n_second_count = '0;
                    n_state        = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_LOAD;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_t            <= '0;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_first_count  <= n_first_count;
            r_second_count <= n_second_count;
            r_t            <= n_t;
            r_rd_vld       <= n_rd_vld;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid     = r_out_valid;
    assign o_common_length = r_out_data;

endmodule

[rtl/lcs_check.sv]
module lcs_check import lcs_pkg::*; #(
    parameter int MAX_LEN = LCS_MAX_LEN,
    localparam int SW     = $clog2(MAX_LEN + 1)
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          i_final_item,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input logic [SW-1:0] o_common_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_common_length))
        else $error("stalled result changed or dropped");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_common_length <= SW'(MAX_LEN))
        else $error("result exceeds maximum length");

    a_run_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_final_item |=> o_in_stall)
        else $error("input taken right after final transfer");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_final_item && !o_out_valid |=> !o_out_valid)
        else $error("result appeared with no run time");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs active after reset");

endmodule

bind lcs_length_engine lcs_check #(
    .MAX_LEN (MAX_LEN)
) u_lcs_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_final_item    (i_final_item),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_common_length (o_common_length)
);
